// ===== rtl/tlsr_pkg.sv =====
// Shared constants and types for the thick line span rasteriser.
`default_nettype none

package tlsr_pkg;

  // Field widths and grid limits
  localparam int COORD_W       = 6;
  localparam int THICK_W       = 5;
  localparam int COORD_MAX     = 63;
  localparam int MAX_THICKNESS = 16;
  localparam int HALF_W        = (MAX_THICKNESS > 1) ? $clog2(MAX_THICKNESS) : 1;

  // Internal arithmetic widths: row can overshoot the grid on steep lines
  localparam int ROW_W  = COORD_W + 2;
  localparam int SPAN_W = ROW_W + 1;
  localparam int DEC_W  = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COORD_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MAX_COL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MAX_ROW = 1'b1;
  localparam logic [COORD_W-1:0]   GRID_MAX_RESET   = 6'd15;

  // One line command
  typedef struct packed {
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] end_col;
    logic [COORD_W-1:0] end_row;
    logic [THICK_W-1:0] thickness;
  } tlsr_cmd_t;

  // One emitted span
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] centre_row;
    logic [COORD_W-1:0] span_low;
    logic [COORD_W-1:0] span_high;
    logic               span_empty;
    logic               last;
  } tlsr_span_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic emit;
  } tlsr_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic at_last;
    logic out_free;
  } tlsr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tlsr_in_if.sv =====
// Line command channel: valid, ready and the command fields.
`default_nettype none

interface tlsr_in_if
  import tlsr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_col;
  logic [COORD_W-1:0] start_row;
  logic [COORD_W-1:0] end_col;
  logic [COORD_W-1:0] end_row;
  logic [THICK_W-1:0] thickness;

  modport source (output valid, start_col, start_row, end_col, end_row, thickness,
                  input ready);
  modport sink   (input valid, start_col, start_row, end_col, end_row, thickness,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tlsr_out_if.sv =====
// Span result channel: valid, ready and the span fields.
`default_nettype none

interface tlsr_out_if
  import tlsr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] centre_row;
  logic [COORD_W-1:0] span_low;
  logic [COORD_W-1:0] span_high;
  logic               span_empty;
  logic               last;

  modport source (output valid, col, centre_row, span_low, span_high, span_empty, last,
                  input ready);
  modport sink   (input valid, col, centre_row, span_low, span_high, span_empty, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/thick_line_span_rasterizer.sv =====
// Top level of the thick line span rasteriser.
//
// A line command word (two endpoints and a thickness) arrives on in_ch.
// The block orders the endpoints so the column rises and walks the columns
// with the midpoint rule, emitting one span word per column on out_ch:
// column, centre row, clipped span rows, an empty flag and a last flag.
// grid_max_col and grid_max_row are written through cfg_we / cfg_index /
// cfg_data; the user must do so only while the block is idle (unchecked).
// The accepted command is registered into the line state, and each span
// word is then loaded into the output register. A command of dx columns
// yields dx + 1 spans at one per cycle while out_ch takes them; the column
// walk of the stepping datapath sets that rate.
// A new command is taken once the final span has been loaded into the
// output register, even while that word still waits to be taken.
// If out_ch stalls, the output register holds its word and the walk
// pauses; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) returns the controller to idle, clears
// the output valid and sets both grid bounds to 15.
`default_nettype none

module thick_line_span_rasterizer
  import tlsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tlsr_in_if.sink                    in_ch,
  tlsr_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tlsr_ctl_t  ctl;
  tlsr_sts_t  sts;
  tlsr_cmd_t  cmd;
  tlsr_span_t span;
  logic       in_ready;
  logic       out_valid;

  always_comb begin
    cmd.start_col = in_ch.start_col;
    cmd.start_row = in_ch.start_row;
    cmd.end_col   = in_ch.end_col;
    cmd.end_row   = in_ch.end_row;
    cmd.thickness = in_ch.thickness;
  end

  tlsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tlsr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_span  (span)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.col        = span.col;
  assign out_ch.centre_row = span.centre_row;
  assign out_ch.span_low   = span.span_low;
  assign out_ch.span_high  = span.span_high;
  assign out_ch.span_empty = span.span_empty;
  assign out_ch.last       = span.last;

endmodule

`default_nettype wire

// ===== rtl/tlsr_ctrl.sv =====
// Controller state machine: takes a command, then emits one span per column.
`default_nettype none

module tlsr_ctrl
  import tlsr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tlsr_sts_t sts,
  output tlsr_ctl_t      ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  // Command and next-state decode
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.emit = sts.out_free;
        if (sts.out_free && sts.at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A new command is never loaded in the same cycle as a span goes out
  a_load_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.emit))
    else $error("load and emit in the same cycle");

  // Emitting the final column returns the controller to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && sts.at_last) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after the final column");
`endif

endmodule

`default_nettype wire

// ===== rtl/tlsr_dp.sv =====
// Datapath: line setup, midpoint stepping, span clipping, output register.
`default_nettype none

module tlsr_dp
  import tlsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tlsr_ctl_t             ctl,
  output tlsr_sts_t                  sts,
  input  wire tlsr_cmd_t             cmd,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tlsr_span_t                 out_span
);

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    return (v > COORD_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : v;
  endfunction

  localparam logic signed [DEC_W-1:0] DEC_MAX = {1'b0, {(DEC_W-1){1'b1}}};
  localparam logic signed [DEC_W-1:0] DEC_MIN = {1'b1, {(DEC_W-1){1'b0}}};

  // Grid bounds
  logic [COORD_W-1:0] grid_max_col_r;
  logic [COORD_W-1:0] grid_max_row_r;

  // Line state
  logic signed [DEC_W-1:0] decision_r, decision_nxt;
  logic [COORD_W-1:0]      cur_col_r, cur_col_nxt;
  logic signed [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COORD_W-1:0]      stop_col_r, stop_col_nxt;
  logic                    step_dir_r, step_dir_nxt;
  logic signed [DEC_W-1:0] inc_straight_r, inc_straight_nxt;
  logic signed [DEC_W-1:0] inc_diagonal_r, inc_diagonal_nxt;
  logic [HALF_W-1:0]       half_span_r, half_span_nxt;
  logic                    half_neg_r, half_neg_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  tlsr_span_t out_span_r, out_span_nxt;

  // Setup signals
  logic [COORD_W-1:0]      c0a, r0a, c1a, r1a, c0, r0, c1, r1, dx_u;
  logic [THICK_W-1:0]      thick_sat;
  logic                    swap, dir_up;
  logic signed [DEC_W-1:0] dx_d, dy_d, dir_dx;

  // Step and span signals
  logic signed [DEC_W:0]    dec_sum;
  logic signed [DEC_W-1:0]  inc_sel, dec_sat;
  logic                     go_straight, dec_pos;
  logic signed [SPAN_W-1:0] row_s, half_s, lo_s, hi_s, lo_c, hi_c, gmr_s;
  logic                     empty;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_max_col_r <= GRID_MAX_RESET;
      grid_max_row_r <= GRID_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_MAX_COL: grid_max_col_r <= cfg_data;
        CFG_GRID_MAX_ROW: grid_max_row_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line setup: order endpoints so the column rises, build the increments
  always_comb begin
    c0a       = clamp_coord(cmd.start_col);
    r0a       = clamp_coord(cmd.start_row);
    c1a       = clamp_coord(cmd.end_col);
    r1a       = clamp_coord(cmd.end_row);
    thick_sat = (cmd.thickness > THICK_W'(MAX_THICKNESS)) ?
                THICK_W'(MAX_THICKNESS) : cmd.thickness;
    swap      = (c1a < c0a);
    c0        = swap ? c1a : c0a;
    r0        = swap ? r1a : r0a;
    c1        = swap ? c0a : c1a;
    r1        = swap ? r0a : r1a;
    dx_u      = c1 - c0;
    dir_up    = (r1 > r0);
    dx_d      = signed'({{(DEC_W-COORD_W){1'b0}}, dx_u});
    dy_d      = signed'({{(DEC_W-COORD_W){1'b0}}, r1}) -
                signed'({{(DEC_W-COORD_W){1'b0}}, r0});
    dir_dx    = dir_up ? -dx_d : dx_d;
  end

  // Midpoint step with a saturating decision value
  always_comb begin
    dec_pos     = !decision_r[DEC_W-1] && (decision_r != '0);
    go_straight = step_dir_r ? decision_r[DEC_W-1] : dec_pos;
    inc_sel     = go_straight ? inc_straight_r : inc_diagonal_r;
    dec_sum     = {decision_r[DEC_W-1], decision_r} + {inc_sel[DEC_W-1], inc_sel};
    if (dec_sum[DEC_W] != dec_sum[DEC_W-1]) begin
      dec_sat = dec_sum[DEC_W] ? DEC_MIN : DEC_MAX;
    end else begin
      dec_sat = dec_sum[DEC_W-1:0];
    end
  end

  // Span around the current row, clipped to the grid
  always_comb begin
    row_s  = {cur_row_r[ROW_W-1], cur_row_r};
    half_s = signed'({{(SPAN_W-HALF_W){1'b0}}, half_span_r});
    gmr_s  = signed'({{(SPAN_W-COORD_W){1'b0}}, grid_max_row_r});
    lo_s   = row_s - half_s;
    hi_s   = row_s + half_s;
    lo_c   = (lo_s < 0) ? '0 : lo_s;
    hi_c   = (hi_s > gmr_s) ? gmr_s : hi_s;
    empty  = (cur_col_r > grid_max_col_r) || half_neg_r || (lo_c > hi_c);
    out_span_nxt.col        = cur_col_r;
    out_span_nxt.centre_row = cur_row_r[COORD_W-1:0];
    out_span_nxt.span_low   = empty ? '0 : lo_c[COORD_W-1:0];
    out_span_nxt.span_high  = empty ? '0 : hi_c[COORD_W-1:0];
    out_span_nxt.span_empty = empty;
    out_span_nxt.last       = (cur_col_r == stop_col_r);
  end

  // Next state of the line registers
  always_comb begin
    decision_nxt     = decision_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    stop_col_nxt     = stop_col_r;
    step_dir_nxt     = step_dir_r;
    inc_straight_nxt = inc_straight_r;
    inc_diagonal_nxt = inc_diagonal_r;
    half_span_nxt    = half_span_r;
    half_neg_nxt     = half_neg_r;
    if (ctl.load) begin
      decision_nxt     = (dy_d <<< 1) + dir_dx;
      inc_straight_nxt = dy_d <<< 1;
      inc_diagonal_nxt = (dy_d + dir_dx) <<< 1;
      cur_col_nxt      = c0;
      cur_row_nxt      = signed'({{(ROW_W-COORD_W){1'b0}}, r0});
      stop_col_nxt     = c1;
      step_dir_nxt     = dir_up;
      half_neg_nxt     = (thick_sat == '0);
      half_span_nxt    = (thick_sat == '0) ? '0 : HALF_W'(thick_sat - 1'b1);
    end else if (ctl.emit && !sts.at_last) begin
      decision_nxt = dec_sat;
      cur_col_nxt  = cur_col_r + 1'b1;
      if (!go_straight) begin
        cur_row_nxt = step_dir_r ? cur_row_r + 1'b1 : cur_row_r - 1'b1;
      end
    end
  end

  always_comb begin
    sts.at_last   = (cur_col_r == stop_col_r);
    sts.out_free  = !out_valid_r || out_ready;
    out_valid_nxt = ctl.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decision_r     <= '0;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      stop_col_r     <= '0;
      step_dir_r     <= 1'b0;
      inc_straight_r <= '0;
      inc_diagonal_r <= '0;
      half_span_r    <= '0;
      half_neg_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      decision_r     <= decision_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      stop_col_r     <= stop_col_nxt;
      step_dir_r     <= step_dir_nxt;
      inc_straight_r <= inc_straight_nxt;
      inc_diagonal_r <= inc_diagonal_nxt;
      half_span_r    <= half_span_nxt;
      half_neg_r     <= half_neg_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Span word register, no reset needed
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_span_r <= out_span_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_span  = out_span_r;

`ifndef NO_ASSERTIONS
  // Setup always orders the endpoints so the walk runs towards the stop column
  a_setup_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (cur_col_r <= stop_col_r))
    else $error("start column beyond stop column after setup");

  // Each non-final span advances the column by exactly one
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && !sts.at_last) |=> (cur_col_r == $past(cur_col_r) + 1'b1))
    else $error("column did not advance by one");

  // An empty span always reads as rows zero to zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_span_r.span_empty) |->
      ((out_span_r.span_low == '0) && (out_span_r.span_high == '0)))
    else $error("empty span carries non-zero rows");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the thick line span rasteriser: directed and random line commands.
module testbench;
  import tlsr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlsr_in_if  cmd_ch ();
  tlsr_out_if span_ch ();

  thick_line_span_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (span_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our copy of the grid bounds, kept in step with every register write
  logic [COORD_W-1:0] vis_max_col;
  logic [COORD_W-1:0] vis_max_row;

  // Span words predicted but not yet seen, oldest first
  tlsr_span_t spans_due[$];

  int  mismatch_count;
  int  lines_sent;
  int  spans_checked;
  int  grid_writes;
  int  cycle_count;
  int  hold_request;
  bit  feed_gaps;
  bit  drain_stalls;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Clip one column's span against the grid and queue the word
  function automatic void queue_span(int col, int row, int half, int stop_col);
    int         lo;
    int         hi;
    bit         empty;
    tlsr_span_t s;
    lo = row - half;
    hi = row + half;
    if (lo < 0) lo = 0;
    if (hi > int'(vis_max_row)) hi = int'(vis_max_row);
    empty = (col > int'(vis_max_col)) || (half < 0) || (lo > hi);
    s.col        = col[COORD_W-1:0];
    s.centre_row = row[COORD_W-1:0];
    s.span_low   = empty ? '0 : lo[COORD_W-1:0];
    s.span_high  = empty ? '0 : hi[COORD_W-1:0];
    s.span_empty = empty;
    s.last       = (col == stop_col);
    spans_due.push_back(s);
  endfunction

  // Midpoint walk of one line command, one queued span per column
  function automatic void trace_line(tlsr_cmd_t cmd);
    int c0, r0, c1, r1, tmp;
    int thick, half, dx, dy, dir;
    int dec, inc_straight, inc_diag, col, row;
    bit rising;
    c0 = cmd.start_col;
    r0 = cmd.start_row;
    c1 = cmd.end_col;
    r1 = cmd.end_row;
    thick = cmd.thickness;
    if (thick > MAX_THICKNESS) thick = MAX_THICKNESS;
    half = thick - 1;
    // column always rises along the walk
    if (c1 < c0) begin
      tmp = c0; c0 = c1; c1 = tmp;
      tmp = r0; r0 = r1; r1 = tmp;
    end
    dx = c1 - c0;
    dy = r1 - r0;
    rising = (r1 > r0);
    dir = rising ? -1 : 1;
    dec          = 2 * dy + dir * dx;
    inc_straight = 2 * dy;
    inc_diag     = 2 * (dy + dir * dx);
    col = c0;
    row = r0;
    queue_span(col, row, half, c1);
    while (col < c1) begin
      if (dec * dir > 0) begin
        dec += inc_straight;
      end else begin
        dec += inc_diag;
        row += rising ? 1 : -1;
      end
      col++;
      queue_span(col, row, half, c1);
    end
  endfunction

  function automatic tlsr_cmd_t line_cmd(int c0, int r0, int c1, int r1, int thick);
    tlsr_cmd_t cmd;
    cmd.start_col = c0[COORD_W-1:0];
    cmd.start_row = r0[COORD_W-1:0];
    cmd.end_col   = c1[COORD_W-1:0];
    cmd.end_row   = r1[COORD_W-1:0];
    cmd.thickness = thick[THICK_W-1:0];
    return cmd;
  endfunction

  // Random command: mostly free endpoints, some short, vertical or steep
  function automatic tlsr_cmd_t random_line();
    int kind, c0, r0, c1, r1, thick;
    kind = $urandom_range(0, 9);
    c0 = $urandom_range(0, COORD_MAX);
    r0 = $urandom_range(0, COORD_MAX);
    c1 = $urandom_range(0, COORD_MAX);
    r1 = $urandom_range(0, COORD_MAX);
    if (kind inside {6, 7}) begin
      c1 = c0 + $urandom_range(0, 8) - 4;
      r1 = r0 + $urandom_range(0, 12) - 6;
    end else if (kind == 8) begin
      c1 = c0;
    end else if (kind == 9) begin
      c1 = c0 + $urandom_range(0, 6) - 3;
    end
    if (c1 < 0) c1 = 0;
    if (c1 > COORD_MAX) c1 = COORD_MAX;
    if (r1 < 0) r1 = 0;
    if (r1 > COORD_MAX) r1 = COORD_MAX;
    if ($urandom_range(0, 3) == 0) thick = $urandom_range(0, 31);
    else thick = $urandom_range(1, MAX_THICKNESS);
    return line_cmd(c0, r0, c1, r1, thick);
  endfunction

  // Input side idle: valid low, payload scrambled
  task automatic feed_idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      cmd_ch.valid     = 1'b0;
      cmd_ch.start_col = COORD_W'($urandom_range(0, COORD_MAX));
      cmd_ch.start_row = COORD_W'($urandom_range(0, COORD_MAX));
      cmd_ch.end_col   = COORD_W'($urandom_range(0, COORD_MAX));
      cmd_ch.end_row   = COORD_W'($urandom_range(0, COORD_MAX));
      cmd_ch.thickness = THICK_W'($urandom_range(0, 31));
    end
  endtask

  // Offer one command word and hold it until taken
  task automatic send_line(tlsr_cmd_t cmd);
    if (feed_gaps && $urandom_range(0, 99) < 35) feed_idle(pick_gap());
    @(negedge clk);
    cmd_ch.valid     = 1'b1;
    cmd_ch.start_col = cmd.start_col;
    cmd_ch.start_row = cmd.start_row;
    cmd_ch.end_col   = cmd.end_col;
    cmd_ch.end_row   = cmd.end_row;
    cmd_ch.thickness = cmd.thickness;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    trace_line(cmd);
    lines_sent++;
  endtask

  // Stop offering and wait for every predicted span word
  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (spans_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_grid_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_GRID_MAX_COL) vis_max_col = value;
    else vis_max_row = value;
    grid_writes++;
  endtask

  task automatic set_grid(int max_col, int max_row);
    write_grid_reg(CFG_GRID_MAX_COL, max_col[COORD_W-1:0]);
    write_grid_reg(CFG_GRID_MAX_ROW, max_row[COORD_W-1:0]);
  endtask

  function automatic void field_mismatch(string name, logic [COORD_W-1:0] want,
                                         logic [COORD_W-1:0] got);
    mismatch_count++;
    $error("%s: expected %0d, actual %0d", name, want, got);
  endfunction

  // Compare one span word with the oldest prediction
  task automatic check_span(tlsr_span_t got);
    tlsr_span_t want;
    if (spans_due.size() == 0) begin
      mismatch_count++;
      $error("span word at col %0d with nothing expected", got.col);
      return;
    end
    want = spans_due.pop_front();
    spans_checked++;
    if (got.col !== want.col) field_mismatch("col", want.col, got.col);
    if (got.centre_row !== want.centre_row)
      field_mismatch("centre_row", want.centre_row, got.centre_row);
    if (got.span_low !== want.span_low)
      field_mismatch("span_low", want.span_low, got.span_low);
    if (got.span_high !== want.span_high)
      field_mismatch("span_high", want.span_high, got.span_high);
    if (got.span_empty !== want.span_empty)
      field_mismatch("span_empty", want.span_empty, got.span_empty);
    if (got.last !== want.last) field_mismatch("last", want.last, got.last);
  endtask

  // Span monitor: sample at the rising edge
  always @(posedge clk) begin
    if (rst_n && span_ch.valid && span_ch.ready)
      check_span({span_ch.col, span_ch.centre_row, span_ch.span_low,
                  span_ch.span_high, span_ch.span_empty, span_ch.last});
  end

  // Span receiver: random stalls plus an occasional long hold-off
  initial begin : span_receiver
    int stall_left;
    stall_left    = 0;
    span_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        span_ch.ready = 1'b0;
        stall_left--;
      end else if (drain_stalls && $urandom_range(0, 99) < 25) begin
        stall_left    = pick_gap() - 1;
        span_ch.ready = 1'b0;
      end else begin
        span_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run timed out with %0d span words outstanding", spans_due.size());
    $display("Mismatches found");
    $finish;
  end

  // Reset bounds of 15: columns and rows past them clip
  task automatic test_default_bounds();
    send_line(line_cmd(0, 5, 20, 5, 3));
    send_line(line_cmd(20, 14, 2, 3, 4));
    wait_drained();
  endtask

  // Extremes of every field and the named corner cases
  task automatic test_directed_lines();
    set_grid(COORD_MAX, COORD_MAX);
    send_line(line_cmd(0, 0, 63, 63, 16));
    send_line(line_cmd(63, 0, 0, 63, 1));
    send_line(line_cmd(63, 63, 0, 0, 31));   // thickness saturates
    send_line(line_cmd(10, 20, 10, 50, 5));  // vertical, end row ignored
    send_line(line_cmd(40, 7, 40, 0, 0));    // vertical, thickness zero
    send_line(line_cmd(3, 30, 25, 30, 0));   // thickness zero, all empty
    send_line(line_cmd(0, 0, 5, 60, 17));    // steep rising
    send_line(line_cmd(2, 63, 6, 0, 2));     // steep falling
    send_line(line_cmd(5, 40, 50, 30, 8));
    send_line(line_cmd(0, 10, 63, 11, 16));
    send_line(line_cmd(63, 31, 63, 31, 1));  // single point
    send_line(line_cmd(1, 1, 62, 2, 16));
    send_line(line_cmd(30, 0, 31, 63, 9));
    send_line(line_cmd(0, 63, 63, 63, 16));  // hugs the top row
    wait_drained();
    set_grid(0, 0);
    send_line(line_cmd(0, 0, 3, 0, 1));
    send_line(line_cmd(0, 5, 2, 9, 3));      // span wholly above the grid
    wait_drained();
    set_grid(5, 40);
    send_line(line_cmd(4, 50, 8, 63, 6));
    send_line(line_cmd(8, 41, 0, 30, 2));
    wait_drained();
  endtask

  // Random commands over several grid settings and idling mixes
  task automatic test_random_lines();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) set_grid(COORD_MAX, COORD_MAX);
      else set_grid($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      feed_gaps    = (phase != 0);
      drain_stalls = (phase != 0) && (phase != 2);
      repeat (20) send_line(random_line());
      wait_drained();
    end
  endtask

  // Receiver holds off while commands keep coming, so the input stalls
  task automatic test_output_hold_off();
    feed_gaps    = 1'b0;
    drain_stalls = 1'b1;
    hold_request = 300;
    repeat (6) send_line(random_line());
    wait_drained();
  endtask

  // Sender sends batches of four commands and waits for every span after each batch
  task automatic test_sender_pause();
    feed_gaps = 1'b1;
    repeat (2) begin
      repeat (4) send_line(random_line());
      wait_drained();
      feed_idle(pick_gap());
    end
  endtask

  // Stimulus sequence
  initial begin
    mismatch_count   = 0;
    lines_sent       = 0;
    spans_checked    = 0;
    grid_writes      = 0;
    hold_request     = 0;
    feed_gaps        = 1'b0;
    drain_stalls     = 1'b0;
    vis_max_col      = GRID_MAX_RESET;
    vis_max_row      = GRID_MAX_RESET;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_GRID_MAX_COL;
    cfg_data         = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.start_col = '0;
    cmd_ch.start_row = '0;
    cmd_ch.end_col   = '0;
    cmd_ch.end_row   = '0;
    cmd_ch.thickness = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_bounds();
    test_directed_lines();
    test_random_lines();
    test_output_hold_off();
    test_sender_pause();

    drain_stalls = 1'b0;
    wait_drained();
    repeat (70) @(posedge clk);

    $display("Sent %0d line commands and checked %0d span words in %0d cycles,",
             lines_sent, spans_checked, cycle_count);
    $display("with %0d grid register writes and both sides idling or stalling.",
             grid_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
